// ===== hdl/nat_pkg.sv =====
// ----------------------------------------------------------------------------
// nat_pkg
// Shared types and constants of the neighbor address table.
// ----------------------------------------------------------------------------
`default_nettype none

package nat_pkg;

   localparam int SLOTS   = 16;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int ID_W    = 8;
   localparam int STR_W   = 8;
   localparam int ENTRY_W = ID_W + STR_W;
   localparam int CNT_W   = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_LIMIT = CSR_INDEX_W'(1);

   localparam logic [ID_W-1:0] OWN_ADDRESS_RESET  = 8'd0;
   localparam logic [ID_W-1:0] CLIENT_LIMIT_RESET = 8'd128;

   typedef enum logic [2:0] {
      REQ_OBSERVE       = 3'd0,
      REQ_NEXT_ABOVE    = 3'd1,
      REQ_NEAREST_BELOW = 3'd2,
      REQ_LOWEST_BELOW  = 3'd3,
      REQ_STRONGEST     = 3'd4,
      REQ_SPAN          = 3'd5
   } req_kind_type;

   typedef struct packed {
      logic [ID_W-1:0] own_address;
      logic [ID_W-1:0] client_limit;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] entries_held;
      logic [CNT_W-1:0] client_count;
      logic [ID_W-1:0]  span_last;
      logic [ID_W-1:0]  span_first;
      logic [ID_W-1:0]  answer_address;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/nat_ram.sv =====
// ----------------------------------------------------------------------------
// nat_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/nat_engine.sv =====
// ----------------------------------------------------------------------------
// nat_engine
// Walks the table RAM once per request: move-to-front on observe, running
// min/max/count on queries.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_engine
   import nat_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_kind,
   input  wire logic [ID_W-1:0]    req_address,
   input  wire logic [STR_W-1:0]   req_strength,
   input  wire cfg_type            cfg,
   output logic                    ram_wr_en,
   output logic [ADDR_W-1:0]       ram_wr_addr,
   output logic [ENTRY_W-1:0]      ram_wr_data,
   output logic [ADDR_W-1:0]       ram_rd_addr,
   input  wire logic [ENTRY_W-1:0] ram_rd_data,
   output logic                    res_valid,
   input  wire logic               res_take,
   output result_type              res
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   req_kind_type        kind_ff, kind_in;
   logic [ID_W-1:0]     ref_ff, ref_in;
   logic [ENTRY_W-1:0]  carry_ff, carry_in;
   logic                found_ff, found_in;
   logic [ID_W-1:0]     ans_ff, ans_in;
   logic [STR_W-1:0]    bests_ff, bests_in;
   logic [ID_W-1:0]     first_ff, first_in;
   logic [ID_W-1:0]     last_ff, last_in;
   logic [CNT_W-1:0]    clients_ff, clients_in;
   result_type          res_ff, res_in;

   logic [ID_W-1:0]     rd_id;
   logic [STR_W-1:0]    rd_str;
   logic [ID_W-1:0]     span_init;
   logic [ID_W-1:0]     acc_ref;
   logic                own_ok;
   logic                ent_ok;
   logic                finish;
   req_kind_type        acc_kind;

   assign rd_id     = ram_rd_data[ENTRY_W-1 -: ID_W];
   assign rd_str    = ram_rd_data[STR_W-1:0];
   assign span_init = (cfg.own_address < cfg.client_limit) ? cfg.own_address
                                                           : cfg.client_limit;
   assign acc_kind  = req_kind_type'(req_kind);
   assign acc_ref   = (req_address != '0) ? req_address : cfg.own_address;
   assign own_ok    = (acc_kind == REQ_NEXT_ABOVE) ? (cfg.own_address > acc_ref)
                                                   : (cfg.own_address < acc_ref);
   assign ent_ok    = (kind_ff == REQ_NEXT_ABOVE) ? (rd_id > ref_ff) : (rd_id < ref_ff);

   assign req_ready   = (state_ff == ST_IDLE);
   assign res_valid   = (state_ff == ST_DONE);
   assign res         = res_ff;
   // read one entry ahead of the one being processed
   assign ram_rd_addr = (state_ff == ST_IDLE) ? '0 : ADDR_W'(idx_ff + 1'b1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      kind_in    = kind_ff;
      ref_in     = ref_ff;
      carry_in   = carry_ff;
      found_in   = found_ff;
      ans_in     = ans_ff;
      bests_in   = bests_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      clients_in = clients_ff;
      res_in     = res_ff;
      finish     = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = carry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in   = ST_SCAN;
               idx_in     = '0;
               kind_in    = acc_kind;
               // observe searches for the raw id, zero included
               ref_in     = (acc_kind == REQ_OBSERVE) ? req_address : acc_ref;
               carry_in   = {req_address, req_strength};
               // own address takes part in the ordering queries
               found_in   = own_ok;
               ans_in     = (acc_kind == REQ_NEXT_ABOVE || acc_kind == REQ_NEAREST_BELOW ||
                             acc_kind == REQ_LOWEST_BELOW) ? cfg.own_address : '0;
               bests_in   = '0;
               first_in   = span_init;
               last_in    = span_init;
               clients_in = '0;
            end
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               finish = 1'b1;
               // new id: the carried entry lands at the tail unless the table is full
               if (kind_ff == REQ_OBSERVE && count_ff != ADDR_W'(SLOTS - 1)) begin
                  ram_wr_en = 1'b1;
                  count_in  = ADDR_W'(count_ff + 1'b1);
               end
            end else begin
               idx_in = ADDR_W'(idx_ff + 1'b1);
               unique case (kind_ff)
                  REQ_OBSERVE: begin
                     ram_wr_en = 1'b1;
                     if (rd_id == ref_ff) begin
                        finish = 1'b1;
                     end else begin
                        carry_in = ram_rd_data;
                     end
                  end
                  REQ_NEXT_ABOVE, REQ_NEAREST_BELOW, REQ_LOWEST_BELOW: begin
                     if (ent_ok) begin
                        found_in = 1'b1;
                        if (!found_ff) begin
                           ans_in = rd_id;
                        end else if (kind_ff == REQ_NEAREST_BELOW) begin
                           ans_in = (rd_id > ans_ff) ? rd_id : ans_ff;
                        end else begin
                           ans_in = (rd_id < ans_ff) ? rd_id : ans_ff;
                        end
                     end
                  end
                  REQ_STRONGEST: begin
                     // strict compare: the most recently heard wins a tie
                     if (rd_str > bests_ff && rd_id < cfg.client_limit) begin
                        bests_in = rd_str;
                        ans_in   = rd_id;
                     end
                  end
                  REQ_SPAN: begin
                     if (rd_id < cfg.client_limit) begin
                        clients_in = CNT_W'(clients_ff + 1'b1);
                        if (rd_id > last_ff)  last_in  = rd_id;
                        if (rd_id < first_ff) first_in = rd_id;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (finish) begin
               state_in = ST_DONE;
               res_in   = '0;
               res_in.entries_held = CNT_W'(count_in);
               unique case (kind_ff)
                  REQ_NEXT_ABOVE, REQ_NEAREST_BELOW, REQ_LOWEST_BELOW:
                     res_in.answer_address = found_ff ? ans_ff : '0;
                  REQ_STRONGEST:
                     res_in.answer_address = ans_ff;
                  REQ_SPAN: begin
                     res_in.span_first   = first_ff;
                     res_in.span_last    = last_ff;
                     res_in.client_count = clients_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      kind_ff    <= kind_in;
      ref_ff     <= ref_in;
      carry_ff   <= carry_in;
      found_ff   <= found_in;
      ans_ff     <= ans_in;
      bests_ff   <= bests_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      clients_ff <= clients_in;
      res_ff     <= res_in;
   end

endmodule

`default_nettype wire

// ===== hdl/neighbor_address_table.sv =====
// Table walk: over the entries held (at most SLOTS-1), one entry per cycle, set by the
// single read port of the table RAM; an observe of a known id ends at its position.
// Requests: one at a time; a new request is taken only when the engine is idle again,
// after the previous result has moved into the rsp_tdata output register.
// Reset: table empty, own_address 0, client_limit 128; no clearing pass.
// ----------------------------------------------------------------------------
// neighbor_address_table
// Most-recently-heard neighbor id table with ordering and client queries.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_address_table
   import nat_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [15:0]            req_tdata,  // query_address, signal_strength
   input  wire logic [2:0]             req_tuser,  // req_type
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [31:0]                 rsp_tdata,  // answer_address, span_first,
                                                   // span_last, client_count,
                                                   // entries_held
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data
);

   cfg_type             cfg_ff, cfg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   logic                res_valid;
   logic                res_take;
   result_type          res;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   // output register takes the result once it is empty or being drained
   assign res_take   = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         priority if (csr_index == CSR_OWN_ADDRESS) begin
            cfg_in.own_address = csr_data;
         end else if (csr_index == CSR_CLIENT_LIMIT) begin
            cfg_in.client_limit = csr_data;
         end else begin
            // other indexes are ignored
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address  <= OWN_ADDRESS_RESET;
         cfg_ff.client_limit <= CLIENT_LIMIT_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   nat_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_address  (req_tdata[7:0]),
      .req_strength (req_tdata[15:8]),
      .cfg          (cfg_ff),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res          (res)
   );

   nat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== test/neighbor_address_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_address_table_tb
// Self-checking bench for the neighbor address table. Streams observe and
// query requests with random bursts and gaps. The result side stalls on its
// own pattern and holds off once for a long stretch. A software copy of the
// move-to-front table predicts every response, which is checked field by
// field. own_address and client_limit are swept through their extremes
// between phases, while the table is idle.
// ----------------------------------------------------------------------------

module neighbor_address_table_tb;
   import nat_pkg::*;

   localparam time CLK_HALF   = 4ns;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 24;     // covers the worst table walk, over SLOTS-1 entries
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASE_ITEMS = 190;
   localparam int HOLDOFF_AFTER = 300;    // requests sent before the long stall
   localparam int HOLDOFF_CYCLES = 400;

   // request kinds the block does not define
   localparam logic [2:0] REQ_RESERVED_6 = 3'd6;
   localparam logic [2:0] REQ_RESERVED_7 = 3'd7;

   // receiver stall patterns
   localparam int READY_ALWAYS = 0;
   localparam int READY_COIN   = 1;
   localparam int READY_SPARSE = 2;

   typedef struct packed {
      logic [2:0]      kind;
      logic [ID_W-1:0] addr;
      logic [STR_W-1:0] strength;
   } nbr_request_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;    // query_address, signal_strength
   logic [2:0]             req_tuser = '0;    // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;         // answer_address, span_first,
                                              // span_last, client_count,
                                              // entries_held
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data = '0;

   neighbor_address_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   nbr_request_type request_queue[$];
   result_type   expected_results[$];
   int           errors = 0;
   int           req_sent = 0;        // written with NBA only, read by receiver

   // ---- predicted table ----
   logic [ID_W-1:0]  nb_ids  [SLOTS];
   logic [STR_W-1:0] nb_strs [SLOTS];
   int unsigned      nb_held = 0;
   logic [ID_W-1:0]  own_q   = OWN_ADDRESS_RESET;
   logic [ID_W-1:0]  limit_q = CLIENT_LIMIT_RESET;

   function automatic result_type predict_request(logic [2:0] kind, logic [ID_W-1:0] addr,
                                                  logic [STR_W-1:0] strength);
      result_type       r;
      logic [ID_W-1:0]  ref_addr;
      logic [ID_W-1:0]  id;
      logic [ID_W-1:0]  best;
      logic [STR_W-1:0] best_str;
      logic             found;
      logic             ok;
      int unsigned      pos;
      int unsigned      top;
      int unsigned      clients;
      r = '0;
      case (kind)
         REQ_OBSERVE: begin
            pos = 0;
            while (pos < nb_held && nb_ids[pos] != addr) pos++;
            if (pos < nb_held) begin
               top = pos;
            end else if (nb_held < SLOTS - 1) begin
               top = nb_held;
               nb_held++;
            end else begin
               top = SLOTS - 2;     // full: oldest entry falls off
            end
            for (int i = top; i > 0; i--) begin
               nb_ids[i]  = nb_ids[i-1];
               nb_strs[i] = nb_strs[i-1];
            end
            nb_ids[0]  = addr;
            nb_strs[0] = strength;
         end
         REQ_NEXT_ABOVE, REQ_NEAREST_BELOW, REQ_LOWEST_BELOW: begin
            ref_addr = (addr != '0) ? addr : own_q;
            found = 1'b0;
            best = '0;
            // own address takes part as one extra candidate
            for (int i = 0; i <= nb_held && i < SLOTS; i++) begin
               id = (i == nb_held) ? own_q : nb_ids[i];
               ok = (kind == REQ_NEXT_ABOVE) ? (id > ref_addr) : (id < ref_addr);
               if (ok) begin
                  if (!found || ((kind == REQ_NEAREST_BELOW) ? (id > best) : (id < best)))
                     best = id;
                  found = 1'b1;
               end
            end
            r.answer_address = best;
         end
         REQ_STRONGEST: begin
            best_str = '0;
            for (int i = 0; i < nb_held; i++) begin
               if (nb_strs[i] > best_str && nb_ids[i] < limit_q) begin
                  best_str = nb_strs[i];
                  r.answer_address = nb_ids[i];
               end
            end
         end
         REQ_SPAN: begin
            r.span_last = (own_q < limit_q) ? own_q : limit_q;
            r.span_first = r.span_last;
            clients = 0;
            for (int i = 0; i < nb_held; i++) begin
               if (nb_ids[i] < limit_q) begin
                  clients++;
                  if (nb_ids[i] > r.span_last) r.span_last = nb_ids[i];
                  if (nb_ids[i] < r.span_first) r.span_first = nb_ids[i];
               end
            end
            r.client_count = clients[CNT_W-1:0];
         end
         default: begin
         end
      endcase
      r.entries_held = nb_held[CNT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // ---- stimulus helpers ----
   int pool_base = 0;
   int pool_span = 0;      // 0: ids from the whole range

   function automatic void add_request(logic [2:0] kind, logic [ID_W-1:0] addr,
                                       logic [STR_W-1:0] strength);
      nbr_request_type item;
      item.kind = kind;
      item.addr = addr;
      item.strength = strength;
      request_queue.push_back(item);
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      if (pool_span == 0) return ID_W'($urandom_range(0, 255));
      return ID_W'(pool_base + $urandom_range(0, pool_span - 1));
   endfunction

   function automatic void add_random_request();
      int               sel;
      logic [2:0]       kind;
      logic [ID_W-1:0]  addr;
      logic [STR_W-1:0] strength;
      sel = $urandom_range(0, 99);
      if (sel < 45)      kind = REQ_OBSERVE;
      else if (sel < 54) kind = REQ_NEXT_ABOVE;
      else if (sel < 63) kind = REQ_NEAREST_BELOW;
      else if (sel < 72) kind = REQ_LOWEST_BELOW;
      else if (sel < 81) kind = REQ_STRONGEST;
      else if (sel < 92) kind = REQ_SPAN;
      else kind = $urandom_range(0, 1) ? REQ_RESERVED_6 : REQ_RESERVED_7;
      sel = $urandom_range(0, 9);
      if (kind != REQ_OBSERVE && sel < 3) addr = '0;
      else if (sel < 8) addr = pick_id();
      else addr = ID_W'($urandom_range(0, 255));
      sel = $urandom_range(0, 9);
      if (sel == 0)      strength = '0;
      else if (sel == 1) strength = '1;
      else               strength = STR_W'($urandom_range(0, 255));
      add_request(kind, addr, strength);
   endfunction

   task automatic wait_idle();
      while (request_queue.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_OWN_ADDRESS:  own_q = value;
         CSR_CLIENT_LIMIT: limit_q = value;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // ---- sender: bursts of random length, random gaps ----
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : sender
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_request(req_tuser, req_tdata[7:0],
                                                       req_tdata[15:8]));
            void'(request_queue.pop_front());
            req_sent <= req_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {request_queue[0].strength, request_queue[0].addr};
               req_tuser  <= request_queue[0].kind;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(0, 2);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---- receiver: changing stall patterns plus one long hold-off ----
   int ready_mode = READY_ALWAYS;
   int mode_left = 0;
   int holdoff_left = 0;
   logic holdoff_done = 1'b0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else if (!holdoff_done && req_sent >= HOLDOFF_AFTER) begin
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
            mode_left <= $urandom_range(50, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            default:      rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // ---- response checker ----
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, got %h", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            check_field("answer_address", want.answer_address, got.answer_address);
            check_field("span_first", want.span_first, got.span_first);
            check_field("span_last", want.span_last, got.span_last);
            check_field("client_count", 8'(want.client_count), 8'(got.client_count));
            check_field("entries_held", 8'(want.entries_held), 8'(got.entries_held));
         end
      end
   end

   // ---- watchdog: no transfer of any kind for too long ----
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---- test sequence ----
   initial begin : sequencer
      logic [7:0] phase_own [6];
      logic [7:0] phase_limit [6];
      foreach (nb_ids[i]) begin
         nb_ids[i] = '0;
         nb_strs[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, boundaries, move-to-front, ties, zero strength
      add_request(REQ_SPAN, 8'd0, 8'd0);
      add_request(REQ_NEXT_ABOVE, 8'd0, 8'd0);
      add_request(REQ_NEAREST_BELOW, 8'd255, 8'd0);
      add_request(REQ_STRONGEST, 8'd0, 8'd0);
      add_request(REQ_RESERVED_6, 8'd0, 8'd0);
      add_request(REQ_OBSERVE, 8'd255, 8'd255);
      add_request(REQ_OBSERVE, 8'd0, 8'd0);
      add_request(REQ_OBSERVE, 8'd127, 8'd0);
      add_request(REQ_STRONGEST, 8'd0, 8'd0);
      add_request(REQ_OBSERVE, 8'd5, 8'd200);
      add_request(REQ_OBSERVE, 8'd9, 8'd200);
      add_request(REQ_STRONGEST, 8'd0, 8'd0);       // tie goes to the newer id
      add_request(REQ_OBSERVE, 8'd5, 8'd100);       // known id moves to front
      add_request(REQ_STRONGEST, 8'd0, 8'd0);
      add_request(REQ_NEXT_ABOVE, 8'd255, 8'd0);
      add_request(REQ_NEXT_ABOVE, 8'd0, 8'd0);
      add_request(REQ_NEAREST_BELOW, 8'd0, 8'd0);
      add_request(REQ_LOWEST_BELOW, 8'd128, 8'd0);  // id 0 qualifies as minimum
      add_request(REQ_LOWEST_BELOW, 8'd10, 8'd0);
      add_request(REQ_NEAREST_BELOW, 8'd200, 8'd0);
      add_request(REQ_SPAN, 8'd0, 8'd0);
      add_request(REQ_OBSERVE, 8'd128, 8'd1);       // just at client limit
      add_request(REQ_SPAN, 8'd77, 8'd33);
      add_request(REQ_RESERVED_7, 8'd255, 8'd255);
      wait_idle();

      phase_own   = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
      phase_limit = '{8'd128, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0};
      phase_own[5]   = 8'($urandom_range(1, 254));
      phase_limit[5] = 8'($urandom_range(1, 254));

      for (int p = 0; p < 6; p++) begin
         if (p != 0) begin
            write_csr(CSR_OWN_ADDRESS, phase_own[p]);
            write_csr(CSR_CLIENT_LIMIT, phase_limit[p]);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // re-pick the id pool now and then: small pools hit often,
            // a pool above SLOTS-1 forces evictions
            if (n % 40 == 0) begin
               case ($urandom_range(0, 3))
                  0: pool_span = 0;
                  1: pool_span = 6;
                  default: pool_span = 20;
               endcase
               case ($urandom_range(0, 2))
                  0: pool_base = int'(limit_q) - 8;
                  1: pool_base = int'(own_q) - 8;
                  default: pool_base = $urandom_range(0, 255);
               endcase
            end
            add_random_request();
         end
         wait_idle();
      end

      if (errors == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
